// ===== rtl/oid_table_get_getnext_macros.svh =====
// Assertion macros used by the port-level checker file.
`ifndef OID_TABLE_GET_GETNEXT_MACROS_SVH
`define OID_TABLE_GET_GETNEXT_MACROS_SVH

// Same-cycle implication, reset-qualified.
`define OIDT_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, reset-qualified.
`define OIDT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/oidt_pkg.sv =====
// Package: sizes, function codes, sequencer states and inter-module structs.
package oidt_pkg;

  localparam int unsigned ENTRIES     = 64;
  localparam int unsigned MAX_OID_LEN = 32;
  localparam int unsigned IDX_W       = $clog2(ENTRIES);
  localparam int unsigned POS_W       = $clog2(MAX_OID_LEN);
  localparam int unsigned LEN_W       = POS_W + 1;
  localparam int unsigned CNT_W       = IDX_W + 1;
  localparam int unsigned TBL_DEPTH   = ENTRIES * MAX_OID_LEN;
  localparam int unsigned TBL_AW      = IDX_W + POS_W;
  localparam int unsigned SUB_W       = 8;
  localparam int unsigned FUNC_W      = 3;

  localparam logic [FUNC_W-1:0] FUNC_WR_SUBID  = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_WR_LENGTH = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_WR_QUERY  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_GET       = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_GETNEXT   = 3'd4;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_OID_LEN);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(ENTRIES);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LEN_RD,
    S_SETUP,
    S_BYTE_RD,
    S_BYTE_CMP,
    S_LEN_CMP,
    S_DONE
  } state_e;

  typedef struct packed {
    logic             tbl_we;
    logic             len_we;
    logic             qry_we;
    logic [IDX_W-1:0] entry;
    logic [POS_W-1:0] pos;
    logic [SUB_W-1:0] value;
    logic [LEN_W-1:0] length;
  } wr_req_t;

  typedef struct packed {
    logic [IDX_W-1:0] entry;
    logic [POS_W-1:0] pos;
  } rd_addr_t;

  typedef struct packed {
    logic [LEN_W-1:0] elen;
    logic [SUB_W-1:0] tsub;
    logic [SUB_W-1:0] qsub;
  } rd_data_t;

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
    return (len > MAX_LEN) ? MAX_LEN : len;
  endfunction

endpackage

// ===== rtl/oidt_cmp.sv =====
// Shared magnitude comparator used for sub-id bytes and lengths.
module oidt_cmp (
  input  logic [oidt_pkg::SUB_W-1:0] a_i,
  input  logic [oidt_pkg::SUB_W-1:0] b_i,
  output logic                       lt_o,
  output logic                       eq_o
);

  assign lt_o = (a_i < b_i);
  assign eq_o = (a_i == b_i);

endmodule

// ===== rtl/oidt_store.sv =====
// Table sub-id, entry length and query sub-id memories with registered reads.
module oidt_store (
  input  logic                clk_i,
  input  oidt_pkg::wr_req_t   wr_i,
  input  oidt_pkg::rd_addr_t  rd_addr_i,
  output oidt_pkg::rd_data_t  rd_data_o
);

  logic [oidt_pkg::SUB_W-1:0] tbl_mem [oidt_pkg::TBL_DEPTH];
  logic [oidt_pkg::LEN_W-1:0] len_mem [oidt_pkg::ENTRIES];
  logic [oidt_pkg::SUB_W-1:0] qry_mem [oidt_pkg::MAX_OID_LEN];

  always_ff @(posedge clk_i) begin
    if (wr_i.tbl_we) begin
      tbl_mem[{wr_i.entry, wr_i.pos}] <= wr_i.value;
    end
    if (wr_i.len_we) begin
      len_mem[wr_i.entry] <= wr_i.length;
    end
    if (wr_i.qry_we) begin
      qry_mem[wr_i.pos] <= wr_i.value;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_o.tsub <= tbl_mem[{rd_addr_i.entry, rd_addr_i.pos}];
    rd_data_o.elen <= len_mem[rd_addr_i.entry];
    rd_data_o.qsub <= qry_mem[rd_addr_i.pos];
  end

endmodule

// ===== rtl/oidt_ctrl.sv =====
// Sequencer: decodes transactions, walks entries and bytes, holds the result.
module oidt_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [oidt_pkg::FUNC_W-1:0]   func_i,
  input  logic [oidt_pkg::IDX_W-1:0]    entry_index_i,
  input  logic [oidt_pkg::POS_W-1:0]    position_i,
  input  logic [oidt_pkg::SUB_W-1:0]    subid_value_i,
  input  logic [oidt_pkg::LEN_W-1:0]    oid_length_i,
  input  logic [oidt_pkg::CNT_W-1:0]    entry_count_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          found_o,
  output logic [oidt_pkg::IDX_W-1:0]    match_index_o,
  output oidt_pkg::wr_req_t             wr_o,
  output oidt_pkg::rd_addr_t            rd_addr_o,
  input  oidt_pkg::rd_data_t            rd_data_i,
  output logic [oidt_pkg::SUB_W-1:0]    cmp_a_o,
  output logic [oidt_pkg::SUB_W-1:0]    cmp_b_o,
  input  logic                          cmp_lt_i,
  input  logic                          cmp_eq_i
);

  oidt_pkg::state_e state_q, state_d;

  logic [oidt_pkg::IDX_W-1:0] idx_q, idx_d;
  logic [oidt_pkg::POS_W-1:0] pos_q, pos_d;
  logic [oidt_pkg::LEN_W-1:0] qlen_q, qlen_d;
  logic [oidt_pkg::LEN_W-1:0] elen_q, elen_d;
  logic [oidt_pkg::LEN_W-1:0] common_q, common_d;
  logic [oidt_pkg::CNT_W-1:0] limit_q, limit_d;
  logic                       next_q, next_d;
  logic                       hit_q, hit_d;
  logic [oidt_pkg::IDX_W-1:0] hit_idx_q, hit_idx_d;
  logic                       out_valid_q, out_valid_d;
  logic                       found_q, found_d;
  logic [oidt_pkg::IDX_W-1:0] match_q, match_d;

  logic                       accept;
  logic                       is_lookup;
  logic [oidt_pkg::CNT_W-1:0] start_limit;
  logic [oidt_pkg::LEN_W-1:0] setup_common;
  logic                       decide;
  logic                       gt;
  logic                       hit;
  logic                       stop;
  logic                       last_entry;
  logic                       last_byte;
  logic                       out_room;

  assign in_ready_o  = (state_q == oidt_pkg::S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign is_lookup   = (func_i == oidt_pkg::FUNC_GET) || (func_i == oidt_pkg::FUNC_GETNEXT);
  assign start_limit = (entry_count_i > oidt_pkg::MAX_CNT) ? oidt_pkg::MAX_CNT : entry_count_i;
  assign setup_common = (rd_data_i.elen < qlen_q) ? rd_data_i.elen : qlen_q;

  assign gt         = !cmp_lt_i && !cmp_eq_i;
  assign hit        = next_q ? gt : cmp_eq_i;
  assign stop       = hit || gt;
  assign decide     = ((state_q == oidt_pkg::S_BYTE_CMP) && !cmp_eq_i) ||
                      (state_q == oidt_pkg::S_LEN_CMP);
  assign last_entry = ({1'b0, idx_q} + oidt_pkg::CNT_W'(1)) == limit_q;
  assign last_byte  = ({1'b0, pos_q} + oidt_pkg::LEN_W'(1)) == common_q;
  assign out_room   = !out_valid_q || out_ready_i;

  assign rd_addr_o.entry = idx_q;
  assign rd_addr_o.pos   = pos_q;

  assign out_valid_o   = out_valid_q;
  assign found_o       = found_q;
  assign match_index_o = match_q;

  always_comb begin
    if (state_q == oidt_pkg::S_LEN_CMP) begin
      cmp_a_o = oidt_pkg::SUB_W'(elen_q);
      cmp_b_o = oidt_pkg::SUB_W'(qlen_q);
    end else begin
      cmp_a_o = rd_data_i.tsub;
      cmp_b_o = rd_data_i.qsub;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      oidt_pkg::S_IDLE: begin
        if (accept && is_lookup) begin
          state_d = (start_limit == '0) ? oidt_pkg::S_DONE : oidt_pkg::S_LEN_RD;
        end
      end
      oidt_pkg::S_LEN_RD: state_d = oidt_pkg::S_SETUP;
      oidt_pkg::S_SETUP: begin
        state_d = (setup_common == '0) ? oidt_pkg::S_LEN_CMP : oidt_pkg::S_BYTE_RD;
      end
      oidt_pkg::S_BYTE_RD: state_d = oidt_pkg::S_BYTE_CMP;
      oidt_pkg::S_BYTE_CMP: begin
        if (!cmp_eq_i) begin
          state_d = (stop || last_entry) ? oidt_pkg::S_DONE : oidt_pkg::S_LEN_RD;
        end else if (last_byte) begin
          state_d = oidt_pkg::S_LEN_CMP;
        end else begin
          state_d = oidt_pkg::S_BYTE_RD;
        end
      end
      oidt_pkg::S_LEN_CMP: begin
        state_d = (stop || last_entry) ? oidt_pkg::S_DONE : oidt_pkg::S_LEN_RD;
      end
      oidt_pkg::S_DONE: begin
        if (out_room) begin
          state_d = oidt_pkg::S_IDLE;
        end
      end
      default: state_d = oidt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    idx_d       = idx_q;
    pos_d       = pos_q;
    qlen_d      = qlen_q;
    elen_d      = elen_q;
    common_d    = common_q;
    limit_d     = limit_q;
    next_d      = next_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    found_d     = found_q;
    match_d     = match_q;

    wr_o.tbl_we = accept && (func_i == oidt_pkg::FUNC_WR_SUBID);
    wr_o.len_we = accept && (func_i == oidt_pkg::FUNC_WR_LENGTH);
    wr_o.qry_we = accept && (func_i == oidt_pkg::FUNC_WR_QUERY);
    wr_o.entry  = entry_index_i;
    wr_o.pos    = position_i;
    wr_o.value  = subid_value_i;
    wr_o.length = oidt_pkg::clamp_len(oid_length_i);

    case (state_q)
      oidt_pkg::S_IDLE: begin
        if (accept && is_lookup) begin
          idx_d     = '0;
          pos_d     = '0;
          qlen_d    = oidt_pkg::clamp_len(oid_length_i);
          limit_d   = start_limit;
          next_d    = (func_i == oidt_pkg::FUNC_GETNEXT);
          hit_d     = 1'b0;
          hit_idx_d = '0;
        end
      end
      oidt_pkg::S_SETUP: begin
        elen_d   = rd_data_i.elen;
        common_d = setup_common;
        pos_d    = '0;
      end
      oidt_pkg::S_BYTE_CMP: begin
        if (cmp_eq_i && !last_byte) begin
          pos_d = pos_q + oidt_pkg::POS_W'(1);
        end
      end
      oidt_pkg::S_DONE: begin
        if (out_room) begin
          out_valid_d = 1'b1;
          found_d     = hit_q;
          match_d     = hit_idx_q;
        end
      end
      default: ;
    endcase

    if (decide) begin
      if (stop) begin
        hit_d     = hit;
        hit_idx_d = hit ? idx_q : '0;
      end else if (!last_entry) begin
        idx_d = idx_q + oidt_pkg::IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= oidt_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    pos_q     <= pos_d;
    qlen_q    <= qlen_d;
    elen_q    <= elen_d;
    common_q  <= common_d;
    limit_q   <= limit_d;
    next_q    <= next_d;
    hit_q     <= hit_d;
    hit_idx_q <= hit_idx_d;
    found_q   <= found_d;
    match_q   <= match_d;
  end

endmodule

// ===== rtl/oid_table_get_getnext.sv =====
// Top level of the OID table get/getnext lookup block.
//
// Input channel (in_valid_i/in_ready_o) carries one transaction per item:
// table sub-id write, entry length write, query sub-id write, get or getnext.
// Writes complete in the accepting cycle and produce no result.
// A get or getnext produces one result transaction (found_o, match_index_o)
// on the output channel (out_valid_o/out_ready_i).
// Lookups are byte-serial through one shared comparator: each entry scanned
// takes a length read (S_LEN_RD, S_SETUP), a read and a compare (S_BYTE_RD,
// S_BYTE_CMP) per sub-id byte compared, and a length compare (S_LEN_CMP) when
// all common bytes match; the result register loads in S_DONE after the scan.
// in_ready_o is low while a lookup runs; writes leave it high.
// The result sits in an output register: the next transaction is accepted
// while it waits, and a second lookup holds in its final step until the
// receiver takes the first result.
// The configuration channel writes entry_count; the user is to do so only while
// the block is idle, which the block itself does not enforce. Reset clears the
// sequencer, the output valid and entry_count; the memories hold garbage until written.
module oid_table_get_getnext (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [oidt_pkg::CNT_W-1:0]  cfg_entry_count_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [oidt_pkg::FUNC_W-1:0] func_i,
  input  logic [oidt_pkg::IDX_W-1:0]  entry_index_i,
  input  logic [oidt_pkg::POS_W-1:0]  position_i,
  input  logic [oidt_pkg::SUB_W-1:0]  subid_value_i,
  input  logic [oidt_pkg::LEN_W-1:0]  oid_length_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        found_o,
  output logic [oidt_pkg::IDX_W-1:0]  match_index_o
);

  logic [oidt_pkg::CNT_W-1:0] entry_count_q;
  oidt_pkg::wr_req_t          wr;
  oidt_pkg::rd_addr_t         rd_addr;
  oidt_pkg::rd_data_t         rd_data;
  logic [oidt_pkg::SUB_W-1:0] cmp_a;
  logic [oidt_pkg::SUB_W-1:0] cmp_b;
  logic                       cmp_lt;
  logic                       cmp_eq;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      entry_count_q <= cfg_entry_count_i;
    end
  end

  oidt_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .entry_index_i (entry_index_i),
    .position_i    (position_i),
    .subid_value_i (subid_value_i),
    .oid_length_i  (oid_length_i),
    .entry_count_i (entry_count_q),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .found_o       (found_o),
    .match_index_o (match_index_o),
    .wr_o          (wr),
    .rd_addr_o     (rd_addr),
    .rd_data_i     (rd_data),
    .cmp_a_o       (cmp_a),
    .cmp_b_o       (cmp_b),
    .cmp_lt_i      (cmp_lt),
    .cmp_eq_i      (cmp_eq)
  );

  oidt_store u_store (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  oidt_cmp u_cmp (
    .a_i  (cmp_a),
    .b_i  (cmp_b),
    .lt_o (cmp_lt),
    .eq_o (cmp_eq)
  );

endmodule

// ===== rtl/oidt_chk.sv =====
// Port-level checker for the OID table lookup block, bound to the top level.
`include "oid_table_get_getnext_macros.svh"

module oidt_chk (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic [oidt_pkg::FUNC_W-1:0] func_i,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic                        found_o,
  input logic [oidt_pkg::IDX_W-1:0]  match_index_o
);

  `OIDT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
    out_valid_o && $stable(found_o) && $stable(match_index_o),
    "result changed while stalled")

  `OIDT_ASSERT_NOW(a_miss_zero, clk_i, rst_ni, out_valid_o && !found_o,
    match_index_o == '0, "not-found result carries a nonzero index")

  `OIDT_ASSERT_NEXT(a_lookup_busy, clk_i, rst_ni,
    in_valid_i && in_ready_o &&
    (func_i == oidt_pkg::FUNC_GET || func_i == oidt_pkg::FUNC_GETNEXT),
    !in_ready_o, "ready after accepting a lookup")

  `OIDT_ASSERT_NEXT(a_write_silent, clk_i, rst_ni,
    in_valid_i && in_ready_o && !out_valid_o &&
    func_i != oidt_pkg::FUNC_GET && func_i != oidt_pkg::FUNC_GETNEXT,
    !out_valid_o, "result raised by a write transaction")

endmodule

bind oid_table_get_getnext oidt_chk u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .func_i        (func_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .found_o       (found_o),
  .match_index_o (match_index_o)
);
